// ===== hdl/swm_pkg.sv =====
// shared types and constants for the sliding window maximum block
package swm_pkg;

  // width of the window size register
  localparam int CFG_W = 11;
  // sample positions count modulo 2^POS_BITS
  localparam int POS_BITS = 32;

  typedef enum logic {
    ST_IDLE,
    ST_EVAL
  } swm_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic drop_front;
    logic drop_back;
    logic push;
    logic load_result;
  } swm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic front_stale;
    logic back_drop;
    logic produce;
  } swm_status_t;

endpackage

// ===== hdl/swm_ifs.sv =====
// stream interfaces for samples in and window maxima out
interface swm_sample_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   last_item;

  modport source (output valid, output sample, output last_item, input ready);
  modport sink (input valid, input sample, input last_item, output ready);
endinterface

interface swm_result_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] window_max;
  logic                   end_of_sequence;

  modport source (output valid, output window_max, output end_of_sequence, input ready);
  modport sink (input valid, input window_max, input end_of_sequence, output ready);
endinterface

// ===== hdl/swm_ctrl.sv =====
// controller state machine for the sliding window maximum block
module swm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  swm_pkg::swm_status_t status,
  output swm_pkg::swm_cmd_t   cmd
);
  import swm_pkg::*;

  swm_state_t state;
  swm_state_t state_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.front_stale) begin
          cmd.drop_front = 1'b1;
        end else if (status.back_drop) begin
          cmd.drop_back = 1'b1;
        end else if (!status.produce || out_free) begin
          cmd.push        = 1'b1;
          cmd.load_result = status.produce;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_result) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

// ===== hdl/swm_dp.sv =====
// datapath: window register, deque memory, counters and result register
module swm_dp #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic [SAMPLE_BITS-1:0]   sample,
  input  logic                     last_item,
  input  swm_pkg::swm_cmd_t        cmd,
  output swm_pkg::swm_status_t     status,
  output logic [SAMPLE_BITS-1:0]   window_max,
  output logic                     end_of_sequence
);
  import swm_pkg::*;

  localparam int AW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW      = AW + 1;
  localparam int CW      = $clog2(MAX_WINDOW + 1);
  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int ENTRY_W = POS_BITS + SAMPLE_BITS;

  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = s;
    if (s >= SW'(MAX_WINDOW)) begin
      t = s - SW'(MAX_WINDOW);
    end
    return t[AW-1:0];
  endfunction

  logic [CFG_W-1:0]       win_size;
  logic [AW-1:0]          head;
  logic [AW-1:0]          head_next;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [POS_BITS-1:0]    spos;
  logic [POS_BITS-1:0]    spos_next;
  logic                   wrapped;
  logic                   wrapped_next;
  logic [SAMPLE_BITS-1:0] item_val;
  logic                   item_last;
  logic [WIN_W-1:0]       item_w;
  logic [WIN_W-1:0]       w_eff;

  logic [ENTRY_W-1:0]     mem [MAX_WINDOW];
  logic [ENTRY_W-1:0]     rd_front;
  logic [SAMPLE_BITS-1:0] rd_back_val;
  logic [AW-1:0]          front_addr;
  logic [AW-1:0]          back_addr;
  logic [AW-1:0]          push_addr;
  logic [POS_BITS-1:0]    front_age;

  // clamp the window to 1..MAX_WINDOW
  always_comb begin
    if (win_size == '0) begin
      w_eff = WIN_W'(1);
    end else if (32'(win_size) > 32'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = WIN_W'(win_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      win_size <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_val  <= sample;
      item_last <= last_item;
      item_w    <= w_eff;
    end
  end

  always_comb begin
    head_next    = head;
    count_next   = count;
    spos_next    = spos;
    wrapped_next = wrapped;
    if (cmd.drop_front) begin
      head_next  = wrap_idx(SW'(head) + SW'(1));
      count_next = count - CW'(1);
    end
    if (cmd.drop_back) begin
      count_next = count - CW'(1);
    end
    if (cmd.push) begin
      count_next = count + CW'(1);
      spos_next  = spos + POS_BITS'(1);
      if (spos_next == '0) begin
        wrapped_next = 1'b1;
      end
      if (item_last) begin
        head_next    = '0;
        count_next   = '0;
        spos_next    = '0;
        wrapped_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      spos    <= '0;
      wrapped <= 1'b0;
    end else begin
      head    <= head_next;
      count   <= count_next;
      spos    <= spos_next;
      wrapped <= wrapped_next;
    end
  end

  // reads track the next head and tail so data is ready when they take effect
  assign front_addr = head_next;
  assign back_addr  = (count_next == '0) ? head_next
                    : wrap_idx(SW'(head_next) + SW'(count_next - CW'(1)));
  assign push_addr  = wrap_idx(SW'(head) + SW'(count));

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[push_addr] <= {spos, item_val};
    end
    rd_front    <= mem[front_addr];
    rd_back_val <= mem[back_addr][SAMPLE_BITS-1:0];
  end

  assign front_age = spos - rd_front[ENTRY_W-1:SAMPLE_BITS];

  always_comb begin
    status.front_stale = (count != '0) && (front_age >= POS_BITS'(item_w));
    status.back_drop   = (count != '0) && ($signed(item_val) >= $signed(rd_back_val));
    status.produce     = wrapped ||
                         (({1'b0, spos} + (POS_BITS+1)'(1)) >= (POS_BITS+1)'(item_w));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      window_max      <= (count == '0) ? item_val : rd_front[SAMPLE_BITS-1:0];
      end_of_sequence <= item_last;
    end
  end

endmodule

// ===== hdl/sliding_window_maximum.sv =====
// sliding window maximum top level: interfaces, controller and datapath
// the result register loads when eval has popped every stale or smaller deque entry and pushes the sample
// a new sample is taken only in idle, after the previous one has been pushed; pops go one at a time
// each entry is popped at most once, so a long stream sees at most one pop per sample on average
// a full result register stalls the push until the result transaction completes
// reset: empty deque, position zero, window size 1; deque memory is not cleared
module sliding_window_maximum #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wr_data,
  swm_sample_if.sink                samples,
  swm_result_if.source              maxima
);
  import swm_pkg::*;

  swm_cmd_t    cmd;
  swm_status_t status;

  // controller: idle accepts one sample transaction, eval pops front, pops back, then pushes
  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (maxima.valid),
    .out_ready (maxima.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: deque memory of (position, value), head and count, result register
  swm_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .sample          (samples.sample),
    .last_item       (samples.last_item),
    .cmd             (cmd),
    .status          (status),
    .window_max      (maxima.window_max),
    .end_of_sequence (maxima.end_of_sequence)
  );

endmodule

// ===== tb/sliding_window_maximum_checker.sv =====
`timescale 1ns / 100ps
// window maximum predictor and result checker for the sliding window maximum block
module sliding_window_maximum_checker #(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wr_data,
  swm_sample_if                     samples,
  swm_result_if                     maxima,
  output int                        fail_count,
  output int                        pending
);
  import swm_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t peak;
    logic    eos;
  } window_result_t;

  // candidate maxima, oldest at front_slot
  sample_t              peak_value [MAX_WINDOW];
  logic [POS_BITS-1:0]  peak_pos   [MAX_WINDOW];
  int unsigned          front_slot;
  int unsigned          live_count;
  logic [POS_BITS-1:0]  seq_pos;
  bit                   pos_wrapped;
  logic [CFG_W-1:0]     window_cfg;
  window_result_t       expected_maxima [$];

  function void clear_window();
    front_slot  = 0;
    live_count  = 0;
    seq_pos     = '0;
    pos_wrapped = 1'b0;
  endfunction

  function void predict_maximum(input sample_t value, input logic last);
    int unsigned    span;
    int unsigned    back_slot;
    window_result_t res;
    span = window_cfg;
    if (span == 0) span = 1;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    // expired entries leave at the front
    while (live_count > 0 && POS_BITS'(seq_pos - peak_pos[front_slot]) >= span) begin
      front_slot = (front_slot + 1) % MAX_WINDOW;
      live_count--;
    end
    // entries no larger than the new sample leave at the back, ties included
    while (live_count > 0 &&
           value >= peak_value[(front_slot + live_count - 1) % MAX_WINDOW])
      live_count--;
    if (live_count >= MAX_WINDOW) begin
      front_slot = (front_slot + 1) % MAX_WINDOW;
      live_count--;
    end
    back_slot = (front_slot + live_count) % MAX_WINDOW;
    peak_value[back_slot] = value;
    peak_pos[back_slot]   = seq_pos;
    live_count++;
    if (pos_wrapped || longint'(seq_pos) + 1 >= longint'(span)) begin
      res.peak = peak_value[front_slot];
      res.eos  = last;
      expected_maxima.insert(expected_maxima.size(), res);
    end
    seq_pos = seq_pos + 1'b1;
    if (seq_pos == '0) pos_wrapped = 1'b1;
    if (last) clear_window();
  endfunction

  // results are checked before the sample of the same edge is predicted
  always @(posedge clk) begin : watch
    window_result_t want;
    if (rst) begin
      clear_window();
      window_cfg = CFG_W'(1);
      expected_maxima.delete();
    end else begin
      if (maxima.valid && maxima.ready) begin
        if (expected_maxima.size() == 0) begin
          $error("window_max: expected none, actual %0d", $signed(maxima.window_max));
          fail_count++;
        end else begin
          want = expected_maxima[0];
          expected_maxima.delete(0);
          if (maxima.window_max !== want.peak) begin
            $error("window_max: expected %0d, actual %0d", $signed(want.peak),
                   $signed(maxima.window_max));
            fail_count++;
          end
          if (maxima.end_of_sequence !== want.eos) begin
            $error("end_of_sequence: expected %0b, actual %0b", want.eos,
                   maxima.end_of_sequence);
            fail_count++;
          end
        end
      end
      if (samples.valid && samples.ready)
        predict_maximum(sample_t'(samples.sample), samples.last_item);
      if (cfg_wr_en) window_cfg = cfg_wr_data;
    end
    pending = expected_maxima.size();
  end

endmodule

// ===== tb/sliding_window_maximum_test.sv =====
`timescale 1ns / 100ps
// stimulus, clocking and verdict for the sliding window maximum testbench
module sliding_window_maximum_test;
  import swm_pkg::*;

  localparam int MAX_WINDOW        = 1024;
  localparam int SAMPLE_BITS       = 32;
  localparam int CLK_HALF          = 5;
  localparam int RESET_CYCLES      = 10;
  // a sample can pop a whole window of entries, so the drain outlasts MAX_WINDOW pops
  localparam int DRAIN_CYCLES      = MAX_WINDOW + 64;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int LONG_HOLD_CYCLES  = 400;
  localparam int SMALL_PHASE_ITEMS = 90;
  localparam int SHORT_PHASE_ITEMS = 40;
  localparam int NUM_PHASES        = 12;
  localparam int LADDER_TOP        = 1000000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int               fail_count;
  int               pending;
  int               results_taken;
  int               cycle_count;
  bit               sender_burst;
  bit               receiver_burst;

  // window sizes per random phase: zero and oversize values exercise the clamp,
  // 2047 gets one sequence long enough to fill the whole window
  int phase_windows [NUM_PHASES] = '{2, 0, 5, 1, 4, 16, 1024, 3, 2047, 9, 7, 2};

  swm_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples ();
  swm_result_if #(.SAMPLE_BITS(SAMPLE_BITS)) maxima ();

  always #(CLK_HALF) clk = ~clk;

  sliding_window_maximum #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .samples    (samples),
    .maxima     (maxima)
  );

  sliding_window_maximum_checker #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .samples    (samples),
    .maxima     (maxima),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // mix of full-range values, a narrow band for ties, extremes and slow ramps
  function automatic sample_t pick_sample(input sample_t prev);
    case ($urandom_range(0, 7))
      0, 1, 2: return sample_t'($urandom);
      3, 4: return sample_t'($urandom_range(0, 8)) - 4;
      5: begin
        case ($urandom_range(0, 3))
          0: return SAMPLE_MAX;
          1: return SAMPLE_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return prev + sample_t'($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  // one sample transaction; valid stays high across back-to-back items
  task automatic send_sample(input sample_t value, input logic last);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      samples.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    samples.valid     <= 1'b1;
    samples.sample    <= value;
    samples.last_item <= last;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
  endtask

  // sender goes quiet until every predicted maximum has been taken
  task automatic wait_results();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // a sample that yields no result may still be popping, so give it time
  task automatic wait_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input int value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(value);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // result side: random stalls, bursts with none, and two long hold-offs
  // that back the block up until it stops taking samples
  initial begin : result_sink
    int stall;
    maxima.ready = 1'b0;
    forever begin
      if (results_taken % 32 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      stall = receiver_burst ? 0 : $urandom_range(0, 4);
      if (results_taken == 150 || results_taken == 700) stall = LONG_HOLD_CYCLES;
      @(negedge clk);
      if (stall > 0) begin
        maxima.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      maxima.ready <= 1'b1;
      @(posedge clk);
      while (!maxima.valid) @(posedge clk);
      results_taken++;
    end
  end

  // run-length guard
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    sample_t     value;
    int unsigned span;
    int          budget;
    int          sent;
    int          seq_len;
    bit          leave_open;
    samples.valid     = 1'b0;
    samples.sample    = '0;
    samples.last_item = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    value             = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, window of one out of reset: every sample is its own maximum
    sender_burst = 1'b0;
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b1);
    // single-sample sequence
    send_sample(sample_t'(42), 1'b1);

    // window of three: equal values replace each other, then a falling run
    // where the front has to expire
    wait_idle();
    write_window(3);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(5), 1'b0);
    send_sample(sample_t'(9), 1'b0);
    send_sample(sample_t'(7), 1'b0);
    send_sample(sample_t'(3), 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(sample_t'(-4), 1'b1);
    // sequence shorter than the window: no result, state still clears
    send_sample(sample_t'(8), 1'b0);
    send_sample(sample_t'(2), 1'b1);
    // sequence exactly one window long, extremes inside it
    send_sample('1, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);

    // random phases, one window size each; a small-window phase may leave
    // its last sequence open so the next size lands mid-sequence
    foreach (phase_windows[p]) begin
      wait_idle();
      write_window(phase_windows[p]);
      span = phase_windows[p] == 0 ? 1 :
             (phase_windows[p] > MAX_WINDOW ? MAX_WINDOW : phase_windows[p]);
      if (phase_windows[p] > MAX_WINDOW) begin
        // mostly falling ladder so the deque holds close to a full window
        sender_burst = 1'b0;
        for (int i = 0; i < MAX_WINDOW + 3; i++) begin
          value = (i % 64 == 63) ? pick_sample(value) : sample_t'(LADDER_TOP - 2 * i);
          send_sample(value, i == MAX_WINDOW + 2);
        end
      end else begin
        budget     = span <= 64 ? SMALL_PHASE_ITEMS : SHORT_PHASE_ITEMS;
        leave_open = span <= 64 && p + 1 < NUM_PHASES && phase_windows[p + 1] <= 64 &&
                     $urandom_range(0, 1) == 1;
        sent = 0;
        while (sent < budget) begin
          seq_len = span <= 64 ? $urandom_range(1, span + 10) :
                                 $urandom_range(1, SHORT_PHASE_ITEMS);
          if (seq_len > budget - sent) seq_len = budget - sent;
          sender_burst = ($urandom_range(0, 3) == 0);
          for (int i = 0; i < seq_len; i++) begin
            // one pause mid-stream until the result side has caught up
            if (p == 2 && sent == budget / 2) wait_results();
            value = pick_sample(value);
            sent++;
            send_sample(value, i == seq_len - 1 && !(leave_open && sent == budget));
          end
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
